// ===== sv/fsrf_pkg.sv =====
// Types and constants shared by the free slot run finder and its checker.
// No dependencies.
package fsrf_pkg;

    localparam int TimeW = 40;
    localparam int SlotSecW = 17;
    localparam int RoleMaskW = 4;
    localparam int CfgIdxW = 2;
    localparam logic [SlotSecW-1:0] DefaultSlotSeconds = SlotSecW'(15 * 60);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_MARK  = 2'd1,
        ACT_SCAN  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FRAME_BEGIN  = 2'd0,
        REG_FRAME_END    = 2'd1,
        REG_SLOT_SECONDS = 2'd2,
        REG_ROLE_MASK    = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_DIV,
        ST_CLEAR,
        ST_MK_DIV1,
        ST_MK_DIV2,
        ST_MK_SETUP,
        ST_MK_WALK,
        ST_SC_READ,
        ST_SC_SKIP,
        ST_SC_RUN,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

endpackage

// ===== sv/fsrf_divider.sv =====
// Restoring divider, one quotient bit per cycle, for slot index arithmetic.
// Depends on no package.
module fsrf_divider #(
    parameter int NumW = 41,
    parameter int DenW = 17
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic            done,
    output logic [NumW-1:0] quot
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] q_reg, q_next;
    logic [DenW:0]   r_reg, r_next;
    logic [DenW-1:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DenW+1:0] trial;

    // Shift one numerator bit into the remainder and subtract when it fits.
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CntW'(NumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {r_reg, q_reg[NumW-1]};
            if (trial >= {2'b00, d_reg}) begin
                r_next = (DenW+1)'(trial - {2'b00, d_reg});
                q_next = {q_reg[NumW-2:0], 1'b1};
            end else begin
                r_next = trial[DenW:0];
                q_next = {q_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== sv/free_slot_run_finder.sv =====
// Free slot run finder: busy periods are rasterised into a one-bit slot map
// held in a synchronous RAM, and scans return the next run of free slots.
// Operation: a clear writes every map slot; a mark runs three divisions (slot count,
// first slot, span) and then writes each marked slot; a scan runs one division,
// walks the slots and then multiplies out the run bounds. One word at a time.
// Reset (aresetn, synchronous, active low) starts a clearing pass through the
// map RAM during which s_tready stays low.
module free_slot_run_finder #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], attendee_role[3:2], period_start[43:4], period_end[83:44]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], free_start[40:1], free_end[80:41]
    output logic [87:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [fsrf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import fsrf_pkg::*;

    localparam int AddrW = $clog2(MAX_SLOTS);
    localparam int CntW = AddrW + 1;
    localparam int QW = TimeW + 1;

    // Configuration registers.
    logic [TimeW-1:0]     frame_begin_reg, frame_end_reg;
    logic [SlotSecW-1:0]  slot_seconds_reg;
    logic [RoleMaskW-1:0] role_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_begin_reg <= '0;
            frame_end_reg <= TimeW'(604800);
            slot_seconds_reg <= SlotSecW'(900);
            role_mask_reg <= RoleMaskW'(15);
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_FRAME_BEGIN:  frame_begin_reg <= cfg_data[TimeW-1:0];
                REG_FRAME_END:    frame_end_reg <= cfg_data[TimeW-1:0];
                REG_SLOT_SECONDS: slot_seconds_reg <= cfg_data[SlotSecW-1:0];
                REG_ROLE_MASK:    role_mask_reg <= cfg_data[RoleMaskW-1:0];
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [SlotSecW-1:0] eff_slot;
    assign eff_slot = (slot_seconds_reg == '0) ? DefaultSlotSeconds : slot_seconds_reg;

    // Busy map RAM: one write port, one registered read port.
    logic          map_mem [MAX_SLOTS];
    logic          map_we;
    logic [AddrW-1:0] map_waddr, map_raddr;
    logic          map_wdata, map_rdata;

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_waddr] <= map_wdata;
        map_rdata <= map_mem[map_raddr];
    end

    // Shared divider.
    logic          div_start, div_done;
    logic [QW-1:0] div_num, div_quot;

    fsrf_divider #(.NumW(QW), .DenW(SlotSecW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (eff_slot),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Control and item registers.
    state_t           state_reg, state_next;
    logic [CntW-1:0]  cursor_reg, cursor_next;
    logic [CntW-1:0]  ptr_reg, ptr_next;
    logic [CntW-1:0]  last_reg, last_next;
    logic [CntW-1:0]  nslots_reg, nslots_next;
    logic [CntW-1:0]  first_reg, first_next;
    logic [QW-1:0]    q1_reg, q1_next;
    logic [1:0]       act_reg, act_next;
    logic [1:0]       role_reg, role_next;
    logic [TimeW-1:0] ps_reg, ps_next, pe_reg, pe_next;
    logic             found_reg, found_next;
    logic [TimeW-1:0] fs_reg, fs_next, fe_reg, fe_next;
    logic             mvalid_reg, mvalid_next;
    logic [CntW+SlotSecW-1:0] prod_reg, prod_next;

    logic [1:0]       in_action, in_role;
    logic [TimeW-1:0] in_ps, in_pe;
    assign in_action = s_tdata[1:0];
    assign in_role   = s_tdata[3:2];
    assign in_ps     = s_tdata[43:4];
    assign in_pe     = s_tdata[83:44];

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign s_fire = s_tvalid && s_tready;

    logic [QW-1:0] clamp_q;
    assign clamp_q = (div_quot > QW'(MAX_SLOTS)) ? QW'(MAX_SLOTS) : div_quot;

    logic [QW:0] last_sum;
    assign last_sum = {1'b0, q1_reg} + {1'b0, div_quot};

    // Last slot when the period starts before the frame: the negative first
    // slot is truncated toward zero, so its magnitude comes off the span.
    logic [QW-1:0] span_q;
    assign span_q = div_quot - q1_reg;

    // Sequencer: next state, map accesses and result capture.
    always_comb begin
        state_next = state_reg;
        cursor_next = cursor_reg;
        ptr_next = ptr_reg;
        last_next = last_reg;
        nslots_next = nslots_reg;
        first_next = first_reg;
        q1_next = q1_reg;
        act_next = act_reg;
        role_next = role_reg;
        ps_next = ps_reg;
        pe_next = pe_reg;
        found_next = found_reg;
        fs_next = fs_reg;
        fe_next = fe_reg;
        prod_next = prod_reg;
        mvalid_next = mvalid_reg;
        map_we = 1'b0;
        map_waddr = ptr_reg[AddrW-1:0];
        map_wdata = 1'b0;
        map_raddr = ptr_reg[AddrW-1:0];
        div_start = 1'b0;
        div_num = {1'b0, frame_end_reg - frame_begin_reg};
        if (mvalid_reg && m_tready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    act_next = in_action;
                    role_next = in_role;
                    ps_next = in_ps;
                    pe_next = in_pe;
                    found_next = 1'b0;
                    fs_next = '0;
                    fe_next = '0;
                    priority case (action_t'(in_action))
                        ACT_CLEAR: begin
                            ptr_next = '0;
                            cursor_next = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_MARK, ACT_SCAN: begin
                            div_start = 1'b1;
                            state_next = ST_CNT_DIV;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_CLEAR: begin
                map_we = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == CntW'(MAX_SLOTS - 1)) begin
                    state_next = (act_reg == ACT_CLEAR) ? ST_OUT : ST_IDLE;
                end
            end
            ST_CNT_DIV: begin
                if (div_done) begin
                    nslots_next = (frame_end_reg <= frame_begin_reg) ? '0
                                  : clamp_q[CntW-1:0];
                    if (act_reg == ACT_SCAN) begin
                        ptr_next = cursor_reg;
                        state_next = ST_SC_READ;
                    end else if (!role_mask_reg[role_reg] ||
                                 frame_end_reg <= frame_begin_reg ||
                                 clamp_q == '0 || pe_reg < ps_reg ||
                                 pe_reg < frame_begin_reg ||
                                 ps_reg > frame_end_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                        div_num = (ps_reg >= frame_begin_reg)
                                  ? {1'b0, ps_reg - frame_begin_reg}
                                  : {1'b0, frame_begin_reg - ps_reg};
                        state_next = ST_MK_DIV1;
                    end
                end
            end
            ST_MK_DIV1: begin
                if (div_done) begin
                    q1_next = div_quot;
                    div_start = 1'b1;
                    div_num = {1'b0, pe_reg - ps_reg};
                    state_next = ST_MK_DIV2;
                end
            end
            ST_MK_DIV2: begin
                if (div_done) begin
                    // Clamp first and last into the frame.
                    if (ps_reg < frame_begin_reg) begin
                        ptr_next = '0;
                        last_next = (span_q >= QW'(nslots_reg))
                                    ? nslots_reg - 1'b1 : span_q[CntW-1:0];
                        state_next = ST_MK_WALK;
                    end else if (q1_reg >= QW'(nslots_reg)) begin
                        state_next = ST_OUT;
                    end else begin
                        ptr_next = q1_reg[CntW-1:0];
                        last_next = (last_sum >= (QW+1)'(nslots_reg))
                                    ? nslots_reg - 1'b1 : last_sum[CntW-1:0];
                        state_next = ST_MK_WALK;
                    end
                end
            end
            ST_MK_WALK: begin
                map_we = 1'b1;
                map_wdata = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == last_reg) state_next = ST_OUT;
            end
            ST_SC_READ: begin
                // Issue a read at the cursor; data returns next cycle.
                if (ptr_reg >= nslots_reg) begin
                    if (cursor_reg < nslots_reg) cursor_next = nslots_reg;
                    state_next = ST_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = ST_SC_SKIP;
                end
            end
            ST_SC_SKIP: begin
                // map_rdata belongs to slot ptr_reg-1.
                map_raddr = ptr_reg[AddrW-1:0];
                if (!map_rdata) begin
                    first_next = ptr_reg - 1'b1;
                    if (ptr_reg >= nslots_reg) begin
                        cursor_next = ptr_reg;
                        state_next = ST_MUL1;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                        state_next = ST_SC_RUN;
                    end
                end else if (ptr_reg >= nslots_reg) begin
                    cursor_next = nslots_reg;
                    state_next = ST_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_SC_RUN: begin
                map_raddr = ptr_reg[AddrW-1:0];
                if (map_rdata) begin
                    cursor_next = ptr_reg - 1'b1;
                    state_next = ST_MUL1;
                end else if (ptr_reg >= nslots_reg) begin
                    cursor_next = ptr_reg;
                    state_next = ST_MUL1;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_MUL1: begin
                prod_next = first_reg * eff_slot;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                fs_next = frame_begin_reg + TimeW'(prod_reg);
                prod_next = cursor_reg * eff_slot;
                found_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (found_reg && act_reg == ACT_SCAN && fe_reg == '0 && !mvalid_reg
                    && state_reg == ST_OUT) begin
                    fe_next = frame_begin_reg + TimeW'(prod_reg);
                end
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            act_reg <= ACT_NONE;
            ptr_reg <= '0;
            cursor_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            act_reg <= act_next;
            ptr_reg <= ptr_next;
            cursor_reg <= cursor_next;
            mvalid_reg <= mvalid_next;
        end
        last_reg <= last_next;
        nslots_reg <= nslots_next;
        first_reg <= first_next;
        q1_reg <= q1_next;
        role_reg <= role_next;
        ps_reg <= ps_next;
        pe_reg <= pe_next;
        found_reg <= found_next;
        fs_reg <= fs_next;
        fe_reg <= fe_next;
        prod_reg <= prod_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {7'd0, fe_reg, fs_reg, found_reg};
endmodule

// ===== sv/free_slot_run_finder_checker.sv =====
// Port-level checker for the free slot run finder, bound to the top level.
// Depends on fsrf_pkg.
module free_slot_run_finder_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    import fsrf_pkg::*;

    // A held result word must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // One word at a time: no input taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted with a result pending");

    // A word not found carries zero times.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[80:1] == '0)
        else $error("empty result carries times");

    // An accepted input word leaves the block busy on the next edge.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepting a word");
endmodule

bind free_slot_run_finder free_slot_run_finder_checker u_chk (.*);
